// ===== rtl/dtpc_pkg.sv =====
// Shared types and constants for the depth to point cloud core.
`timescale 1ns / 1ps
package dtpc_pkg;

  localparam int MAG_W    = 25;
  localparam int DEN_W    = 48;
  localparam int DVS_W    = DEN_W + 1;
  localparam int NUM_W    = 63;
  localparam int Q_W      = 33;
  localparam int REM_W    = DVS_W + 1;
  localparam int COUNT_W  = 25;
  localparam int SIZE_W   = 14;
  localparam int FIFO_DEPTH = 2;

  localparam logic [2:0] REG_ENABLE   = 3'd0;
  localparam logic [2:0] REG_WIDTH    = 3'd1;
  localparam logic [2:0] REG_HEIGHT   = 3'd2;
  localparam logic [2:0] REG_FOCAL_X  = 3'd3;
  localparam logic [2:0] REG_FOCAL_Y  = 3'd4;
  localparam logic [2:0] REG_CENTER_X = 3'd5;
  localparam logic [2:0] REG_CENTER_Y = 3'd6;
  localparam logic [2:0] REG_MIN_INV  = 3'd7;

  typedef struct packed {
    logic               kept;
    logic               last;
    logic [23:0]        d;
    logic               neg_x;
    logic [MAG_W-1:0]   mag_x;
    logic               neg_y;
    logic [MAG_W-1:0]   mag_y;
    logic [COUNT_W-1:0] count;
  } dtpc_job_t;

  typedef struct packed {
    logic        push;
    logic        full;
    logic        pop;
    logic        empty;
  } dtpc_q_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } dtpc_state_t;

endpackage

// ===== rtl/dtpc_front.sv =====
// Front end: raster position tracking, pixel classification and job build.
`timescale 1ns / 1ps
module dtpc_front
  import dtpc_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [23:0]       in_inv_depth,
  input  logic              enable,
  input  logic [12:0]       frame_width,
  input  logic [12:0]       frame_height,
  input  logic [23:0]       center_x,
  input  logic [23:0]       center_y,
  input  logic [23:0]       min_inv_depth,
  input  logic              q_full,
  output logic              q_push,
  output dtpc_job_t         q_job
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0]      column_r, column_nxt;
  logic [RW-1:0]      row_r, row_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt, count_inc;
  logic [SIZE_W-1:0]  width, height;
  logic               accept, row_end, last, kept;
  logic [25:0]        diff_x, diff_y;

  always_comb begin
    if (frame_width == 13'd0) width = SIZE_W'(1);
    else if (SIZE_W'(frame_width) > SIZE_W'(MAX_WIDTH)) width = SIZE_W'(MAX_WIDTH);
    else width = SIZE_W'(frame_width);
    if (frame_height == 13'd0) height = SIZE_W'(1);
    else if (SIZE_W'(frame_height) > SIZE_W'(MAX_HEIGHT)) height = SIZE_W'(MAX_HEIGHT);
    else height = SIZE_W'(frame_height);
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign row_end  = (SIZE_W'(column_r) + SIZE_W'(1)) >= width;
  assign last     = row_end && ((SIZE_W'(row_r) + SIZE_W'(1)) >= height);
  assign kept     = enable && (in_inv_depth != 24'd0) && (in_inv_depth >= min_inv_depth);
  assign count_inc = (kept && count_r != {COUNT_W{1'b1}}) ? count_r + COUNT_W'(1) : count_r;

  assign diff_x = {1'b0, 13'(column_r), 12'b0} - {2'b0, center_x};
  assign diff_y = {1'b0, 13'(row_r), 12'b0} - {2'b0, center_y};

  always_comb begin
    q_job.kept  = kept;
    q_job.last  = last;
    q_job.d     = in_inv_depth;
    q_job.neg_x = diff_x[25];
    q_job.mag_x = diff_x[25] ? MAG_W'(-diff_x) : diff_x[MAG_W-1:0];
    q_job.neg_y = diff_y[25];
    q_job.mag_y = diff_y[25] ? MAG_W'(-diff_y) : diff_y[MAG_W-1:0];
    q_job.count = count_inc;
  end

  assign q_push = accept && enable && (kept || last);

  always_comb begin
    column_nxt = column_r;
    row_nxt    = row_r;
    count_nxt  = count_r;
    if (accept) begin
      count_nxt = count_inc;
      if (row_end) begin
        column_nxt = '0;
        if (last) begin
          row_nxt   = '0;
          count_nxt = '0;
        end else begin
          row_nxt = row_r + RW'(1);
        end
      end else begin
        column_nxt = column_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      row_r    <= '0;
      count_r  <= '0;
    end else begin
      column_r <= column_nxt;
      row_r    <= row_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/dtpc_fifo.sv =====
// Two-entry job queue between front and back.
`timescale 1ns / 1ps
module dtpc_fifo
  import dtpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dtpc_q_ctl_t ctl_in,
  output logic        full,
  output logic        empty,
  input  dtpc_job_t   wr_job,
  output dtpc_job_t   rd_job
);

  dtpc_job_t mem_r [FIFO_DEPTH];
  logic      wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;

  assign full   = fill_r == 2'(FIFO_DEPTH);
  assign empty  = fill_r == 2'd0;
  assign rd_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (ctl_in.push) mem_r[wr_ptr_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= '0;
    end else begin
      if (ctl_in.push) wr_ptr_r <= !wr_ptr_r;
      if (ctl_in.pop)  rd_ptr_r <= !rd_ptr_r;
      if (ctl_in.push && !ctl_in.pop)      fill_r <= fill_r + 2'd1;
      else if (!ctl_in.push && ctl_in.pop) fill_r <= fill_r - 2'd1;
    end
  end

endmodule

// ===== rtl/dtpc_back.sv =====
// Back end: focal multiply, shared radix-2 divider, saturation and result register.
`timescale 1ns / 1ps
module dtpc_back
  import dtpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  output logic               q_pop,
  input  dtpc_job_t          q_job,
  input  logic [23:0]        focal_x,
  input  logic [23:0]        focal_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_point_valid,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic [31:0]        out_point_z,
  output logic               out_frame_end,
  output logic [24:0]        out_point_count
);

  dtpc_state_t state_r, state_nxt;
  dtpc_job_t   job_r;
  logic [1:0]  phase_r;
  logic [5:0]  cnt_r;
  logic [DEN_W-1:0] den_r;
  logic [DVS_W-1:0] dvs_r;
  logic [REM_W-1:0] rem_r;
  logic [Q_W-1:0]   num_r, q_r;
  logic             ovf_r;
  logic [31:0]      px_r, py_r, pz_r;
  logic             out_valid_r;

  logic [23:0]      fxe, fye;
  logic [MAG_W-1:0] mag_sel;
  logic             neg_sel;
  logic [NUM_W-1:0] n_val;
  logic [DVS_W-1:0] dvs_val;
  logic             ovf_val;
  logic [REM_W-1:0] t_val;
  logic             ge;
  logic [31:0]      sat_val;
  logic             out_free;

  assign fxe = (focal_x == 24'd0) ? 24'd1 : focal_x;
  assign fye = (focal_y == 24'd0) ? 24'd1 : focal_y;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    unique case (phase_r)
      2'd0:    begin mag_sel = job_r.mag_x; neg_sel = job_r.neg_x; end
      2'd1:    begin mag_sel = job_r.mag_y; neg_sel = job_r.neg_y; end
      default: begin mag_sel = MAG_W'(1);   neg_sel = 1'b0;        end
    endcase
    n_val   = {1'b0, mag_sel, 37'b0} + NUM_W'(den_r);
    dvs_val = {den_r, 1'b0};
    ovf_val = {19'b0, n_val} >= {dvs_val, 33'b0};
    t_val   = {rem_r[REM_W-2:0], num_r[Q_W-1]};
    ge      = t_val >= {1'b0, dvs_r};
    if (phase_r == 2'd2) begin
      sat_val = (ovf_r || q_r[32]) ? 32'hFFFF_FFFF : q_r[31:0];
    end else if (!neg_sel) begin
      sat_val = (ovf_r || q_r > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q_r[31:0];
    end else begin
      sat_val = (ovf_r || q_r > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(-q_r[31:0]);
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = q_job.kept ? ST_MUL : ST_OUT;
        end
      end
      ST_MUL:  state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == 6'd1) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = (phase_r == 2'd2) ? ST_OUT : ST_MUL;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        job_r   <= q_job;
        phase_r <= 2'd0;
        px_r    <= '0;
        py_r    <= '0;
        pz_r    <= '0;
      end
      ST_MUL: begin
        case (phase_r)
          2'd0:    den_r <= fxe * job_r.d;
          2'd1:    den_r <= fye * job_r.d;
          default: den_r <= DEN_W'(job_r.d);
        endcase
      end
      ST_LOAD: begin
        dvs_r <= dvs_val;
        ovf_r <= ovf_val;
        rem_r <= REM_W'(n_val[NUM_W-1:Q_W]);
        num_r <= n_val[Q_W-1:0];
        q_r   <= '0;
        cnt_r <= 6'(Q_W);
      end
      ST_DIV: begin
        rem_r <= ge ? t_val - {1'b0, dvs_r} : t_val;
        num_r <= {num_r[Q_W-2:0], 1'b0};
        q_r   <= {q_r[Q_W-2:0], ge};
        cnt_r <= cnt_r - 6'd1;
      end
      ST_FIN: begin
        case (phase_r)
          2'd0:    px_r <= sat_val;
          2'd1:    py_r <= sat_val;
          default: pz_r <= sat_val;
        endcase
        phase_r <= phase_r + 2'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_point_valid <= job_r.kept;
      out_point_x     <= px_r;
      out_point_y     <= py_r;
      out_point_z     <= pz_r;
      out_frame_end   <= job_r.last;
      out_point_count <= job_r.count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/depth_to_point_cloud_core.sv =====
// Top level of the depth to point cloud core: registers, front, queue and back.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_inv_depth
//   out      output     out_valid / out_ready  out_point_valid/x/y/z, out_frame_end, out_point_count
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// The front takes one pixel per cycle while the two-entry queue has room; dropped pixels
// enter the queue only when they end the frame. A kept pixel is worked in the back by
// the one-bit-per-cycle divider shared by x, y and z; a frame end with no point skips it.
// Reset (synchronous, rst_n low) clears position, count, queue and out_valid, not the result data.
// A stalled result holds in the output register while the back finishes the next job.
`timescale 1ns / 1ps
module depth_to_point_cloud_core
  import dtpc_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [23:0]        in_inv_depth,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_point_valid,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic [31:0]        out_point_z,
  output logic               out_frame_end,
  output logic [24:0]        out_point_count,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  logic        enable_r;
  logic [12:0] width_r, height_r;
  logic [23:0] focal_x_r, focal_y_r, center_x_r, center_y_r, min_inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      width_r    <= 13'd640;
      height_r   <= 13'd480;
      focal_x_r  <= 24'd1777827;
      focal_y_r  <= 24'd1776921;
      center_x_r <= 24'd1340417;
      center_y_r <= 24'd985200;
      min_inv_r  <= 24'd1049;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:   enable_r   <= cfg_data[0];
        REG_WIDTH:    width_r    <= cfg_data[12:0];
        REG_HEIGHT:   height_r   <= cfg_data[12:0];
        REG_FOCAL_X:  focal_x_r  <= cfg_data;
        REG_FOCAL_Y:  focal_y_r  <= cfg_data;
        REG_CENTER_X: center_x_r <= cfg_data;
        REG_CENTER_Y: center_y_r <= cfg_data;
        REG_MIN_INV:  min_inv_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  dtpc_q_ctl_t q_ctl;
  dtpc_job_t   push_job, head_job;

  dtpc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_inv_depth  (in_inv_depth),
    .enable        (enable_r),
    .frame_width   (width_r),
    .frame_height  (height_r),
    .center_x      (center_x_r),
    .center_y      (center_y_r),
    .min_inv_depth (min_inv_r),
    .q_full        (q_ctl.full),
    .q_push        (q_ctl.push),
    .q_job         (push_job)
  );

  dtpc_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_in (q_ctl),
    .full   (q_ctl.full),
    .empty  (q_ctl.empty),
    .wr_job (push_job),
    .rd_job (head_job)
  );

  dtpc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_ctl.empty),
    .q_pop           (q_ctl.pop),
    .q_job           (head_job),
    .focal_x         (focal_x_r),
    .focal_y         (focal_y_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_point_valid (out_point_valid),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_point_z     (out_point_z),
    .out_frame_end   (out_frame_end),
    .out_point_count (out_point_count)
  );

endmodule
